### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros used by the top-level RTL file of the token counter.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a condition implies another one in the same cycle.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that a condition implies another one in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/gdtc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdtc_pkg
// Shared widths, command codes and byte helpers of the token counter.
// ----------------------------------------------------------------------------
package gdtc_pkg;

   localparam int DICT_ENTRIES_DEF = 256;
   localparam int MAX_MATCH_DEF    = 8;

   localparam int WORD_BITS     = 64;
   localparam int LEN_BITS      = 4;
   localparam int BYTE_BITS     = 8;
   localparam int INDEX_BITS    = 8;
   localparam int CMD_BITS      = 2;
   localparam int COUNT_BITS    = 32;
   localparam int OVERHEAD_BITS = 16;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_WORD_BIT  = 2;

   // Register word index on the configuration port
   localparam logic REG_FIXED_OVERHEAD = 1'b0;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_WRITE = 2'd0,
      CMD_BYTE  = 2'd1,
      CMD_END   = 2'd2
   } cmd_type;

   // Mask of the lowest nbytes bytes; eight or more selects the whole word
   function automatic logic [WORD_BITS-1:0] byte_mask(input logic [LEN_BITS-1:0] nbytes);
      logic [WORD_BITS-1:0] m;
      m = '0;
      for (int i = 0; i < WORD_BITS / BYTE_BITS; i++) begin
         if (LEN_BITS'(i) < nbytes) begin
            m[BYTE_BITS*i +: BYTE_BITS] = '1;
         end
      end
      return m;
   endfunction

   // ASCII whitespace and punctuation end a word
   function automatic logic is_delimiter(input logic [BYTE_BITS-1:0] b);
      return b inside {[8'h09:8'h0D], 8'h20, [8'h21:8'h2F], [8'h3A:8'h40],
                       [8'h5B:8'h60], [8'h7B:8'h7E]};
   endfunction

endpackage

### hdl/gdtc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdtc_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module gdtc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/greedy_dictionary_token_counter.sv
// Steps: a dictionary write reads the old slot and writes it in ST_WR_CHECK; a text
// byte or end of text goes to ST_DECIDE; each match runs ST_SCAN, ST_TAIL, ST_APPLY.
// Throughput: one item at a time; a match sweeps the dictionary RAM through its
// single read port and one shared compare unit, one entry per cycle.
// Reset: synchronous; a clearing pass over every dictionary slot follows with
// req_ready low, while csr writes are taken as usual.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// greedy_dictionary_token_counter
// Counts tokens of a byte text by greedy longest-prefix matching against a
// loaded dictionary of strings of up to eight bytes. Whitespace and
// punctuation bytes count one token each and end the current word.
// ----------------------------------------------------------------------------
module greedy_dictionary_token_counter #(
   parameter int DICT_ENTRIES = gdtc_pkg::DICT_ENTRIES_DEF,
   parameter int MAX_MATCH    = gdtc_pkg::MAX_MATCH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // Input channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [gdtc_pkg::CMD_BITS-1:0]       req_command,
   input  logic [gdtc_pkg::INDEX_BITS-1:0]     req_entry_index,
   input  logic [gdtc_pkg::WORD_BITS-1:0]      req_entry_bytes,
   input  logic [gdtc_pkg::LEN_BITS-1:0]       req_entry_length,
   input  logic [gdtc_pkg::BYTE_BITS-1:0]      req_text_byte,
   // Result channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [gdtc_pkg::COUNT_BITS-1:0]     rsp_token_count,
   // Configuration port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [gdtc_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [gdtc_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [gdtc_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                                csr_pready
);

   import gdtc_pkg::*;

   localparam int AW = (DICT_ENTRIES > 1) ? $clog2(DICT_ENTRIES) : 1;
   localparam int CW = $clog2(DICT_ENTRIES + 1);
   localparam int RW = WORD_BITS + LEN_BITS;
   localparam int SW = INDEX_BITS + 9;

   localparam logic [AW-1:0]       LastAddr   = AW'(DICT_ENTRIES - 1);
   localparam logic [SW-1:0]       DictDepth  = SW'(DICT_ENTRIES);
   localparam logic [LEN_BITS-1:0] MaxMatchW  = LEN_BITS'(MAX_MATCH);
   localparam logic [CW-1:0]       CountLimit = CW'(DICT_ENTRIES);

   typedef enum logic [6:0] {
      ST_IDLE     = 7'b0000001,
      ST_CLEAR    = 7'b0000010,
      ST_WR_CHECK = 7'b0000100,
      ST_DECIDE   = 7'b0001000,
      ST_SCAN     = 7'b0010000,
      ST_TAIL     = 7'b0100000,
      ST_APPLY    = 7'b1000000
   } state_type;

   // Sequencer
   state_type                 state_ff, state_in;
   logic [AW-1:0]             addr_ff, addr_in;
   logic                      cmp_valid_ff, cmp_valid_in;
   logic [LEN_BITS-1:0]       best_ff, best_in;
   logic                      delim_ff, delim_in;
   logic                      end_ff, end_in;

   // Text state
   logic [WORD_BITS-1:0]      window_ff, window_in;
   logic [LEN_BITS-1:0]       fill_ff, fill_in;
   logic [COUNT_BITS-1:0]     running_ff, running_in;
   logic [COUNT_BITS-1:0]     length_ff, length_in;

   // Dictionary bookkeeping and configuration
   logic [CW-1:0]             count_ff, count_in;
   logic [OVERHEAD_BITS-1:0]  overhead_ff, overhead_in;

   // Pending dictionary write
   logic [AW-1:0]             wr_slot_ff, wr_slot_in;
   logic [LEN_BITS-1:0]       wr_len_ff, wr_len_in;
   logic [WORD_BITS-1:0]      wr_bytes_ff, wr_bytes_in;

   // Result register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [COUNT_BITS-1:0]     rsp_count_ff, rsp_count_in;

   // Dictionary RAM
   logic                      ram_wr_en;
   logic [AW-1:0]             ram_wr_addr;
   logic [RW-1:0]             ram_wr_data;
   logic [AW-1:0]             ram_rd_addr;
   logic [RW-1:0]             ram_rd_data;
   logic [WORD_BITS-1:0]      entry_str;
   logic [LEN_BITS-1:0]       entry_len;

   // Helpers
   logic                      req_fire;
   logic                      csr_write;
   logic [SW-1:0]             slot_ext;
   logic                      slot_ok;
   logic                      need_match;
   logic                      cmp_hit;
   logic [LEN_BITS-1:0]       taken;
   logic [COUNT_BITS-1:0]     running_inc;
   logic [COUNT_BITS-1:0]     fallback;
   logic [COUNT_BITS-1:0]     end_result;

   gdtc_ram #(
      .WIDTH (RW),
      .DEPTH (DICT_ENTRIES)
   ) u_dict_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign entry_str = ram_rd_data[WORD_BITS-1:0];
   assign entry_len = ram_rd_data[RW-1:WORD_BITS];

   // Handshakes: one item at a time, taken only when the sequencer rests
   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_token_count = rsp_count_ff;

   // Configuration port: zero wait states
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[CSR_WORD_BIT] == REG_FIXED_OVERHEAD) ?
                       CSR_DATA_BITS'(overhead_ff) : '0;

   // Slots at or beyond the dictionary depth drop the write
   assign slot_ext = SW'(req_entry_index);
   assign slot_ok  = slot_ext < DictDepth;

   // A delimiter or end of text drains the word; otherwise decide only on a full window
   assign need_match = (delim_ff || end_ff) ? (fill_ff != '0) : (fill_ff >= MaxMatchW);

   // Shared compare unit: one stored entry per cycle against the window.
   // Keep the longest entry that fits the waiting bytes; sweeping every slot
   // once gives the same choice as a longest-first search.
   assign cmp_hit = cmp_valid_ff && (entry_len != '0) && (entry_len <= fill_ff) &&
                    (entry_len > best_ff) &&
                    (entry_str == (window_ff & byte_mask(entry_len)));

   // A miss consumes one byte
   assign taken = (best_ff == '0) ? LEN_BITS'(1) : best_ff;

   assign running_inc = (running_ff == '1) ? running_ff : running_ff + COUNT_BITS'(1);

   // ceil(length / 4) + overhead stays below 2^32, so no saturation is needed here
   assign fallback = {2'b00, length_ff[COUNT_BITS-1:2]} +
                     COUNT_BITS'(length_ff[1:0] != 2'b00) +
                     COUNT_BITS'(overhead_ff);

   assign end_result = (length_ff == '0) ? COUNT_BITS'(overhead_ff) :
                       (count_ff == '0)  ? fallback : running_ff;

   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      cmp_valid_in = 1'b0;
      best_in      = cmp_hit ? entry_len : best_ff;
      delim_in     = delim_ff;
      end_in       = end_ff;
      window_in    = window_ff;
      fill_in      = fill_ff;
      running_in   = running_ff;
      length_in    = length_ff;
      count_in     = count_ff;
      overhead_in  = overhead_ff;
      wr_slot_in   = wr_slot_ff;
      wr_len_in    = wr_len_ff;
      wr_bytes_in  = wr_bytes_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_count_in = rsp_count_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = addr_ff;
      ram_wr_data  = '0;
      ram_rd_addr  = addr_ff;

      if (csr_write && (csr_paddr[CSR_WORD_BIT] == REG_FIXED_OVERHEAD)) begin
         overhead_in = csr_pwdata[OVERHEAD_BITS-1:0];
      end

      case (state_ff)
         ST_CLEAR: begin
            // Zero every length so that each slot starts out invalid
            ram_wr_en = 1'b1;
            if (addr_ff == LastAddr) begin
               addr_in  = '0;
               state_in = ST_IDLE;
            end else begin
               addr_in = addr_ff + AW'(1);
            end
         end

         ST_IDLE: begin
            if (req_fire) begin
               case (cmd_type'(req_command))
                  CMD_WRITE: begin
                     // Read the old slot first to keep the valid count exact
                     if (slot_ok) begin
                        ram_rd_addr = slot_ext[AW-1:0];
                        wr_slot_in  = slot_ext[AW-1:0];
                        wr_len_in   = req_entry_length;
                        wr_bytes_in = req_entry_bytes & byte_mask(req_entry_length);
                        state_in    = ST_WR_CHECK;
                     end
                  end
                  CMD_BYTE: begin
                     length_in = (length_ff == '1) ? length_ff : length_ff + COUNT_BITS'(1);
                     if (is_delimiter(req_text_byte)) begin
                        delim_in = 1'b1;
                     end else begin
                        window_in = window_ff |
                                    (WORD_BITS'(req_text_byte) << {fill_ff[2:0], 3'b000});
                        fill_in   = fill_ff + LEN_BITS'(1);
                     end
                     state_in = ST_DECIDE;
                  end
                  CMD_END: begin
                     end_in   = 1'b1;
                     state_in = ST_DECIDE;
                  end
                  default: begin
                     // Drop the unused command code
                  end
               endcase
            end
         end

         ST_WR_CHECK: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = wr_slot_ff;
            ram_wr_data = {wr_len_ff, wr_bytes_ff};
            if ((entry_len != '0) && (wr_len_ff == '0)) begin
               count_in = count_ff - CW'(1);
            end else if ((entry_len == '0) && (wr_len_ff != '0)) begin
               count_in = count_ff + CW'(1);
            end
            state_in = ST_IDLE;
         end

         ST_DECIDE: begin
            if (need_match) begin
               addr_in  = '0;
               best_in  = '0;
               state_in = ST_SCAN;
            end else if (delim_ff) begin
               running_in = running_inc;
               delim_in   = 1'b0;
               state_in   = ST_IDLE;
            end else if (end_ff) begin
               // Hold here until the result register frees up
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_in = 1'b1;
                  rsp_count_in = end_result;
                  window_in    = '0;
                  fill_in      = '0;
                  running_in   = '0;
                  length_in    = '0;
                  end_ff_clear: begin
                     end_in = 1'b0;
                  end
                  state_in     = ST_IDLE;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end

         ST_SCAN: begin
            cmp_valid_in = 1'b1;
            if (addr_ff == LastAddr) begin
               state_in = ST_TAIL;
            end else begin
               addr_in = addr_ff + AW'(1);
            end
         end

         ST_TAIL: begin
            // Last entry reaches the compare unit this cycle
            state_in = ST_APPLY;
         end

         ST_APPLY: begin
            running_in = running_inc;
            window_in  = window_ff >> {taken, 3'b000};
            fill_in    = fill_ff - taken;
            state_in   = ST_DECIDE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         addr_ff      <= '0;
         cmp_valid_ff <= 1'b0;
         delim_ff     <= 1'b0;
         end_ff       <= 1'b0;
         window_ff    <= '0;
         fill_ff      <= '0;
         running_ff   <= '0;
         length_ff    <= '0;
         count_ff     <= '0;
         overhead_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         cmp_valid_ff <= cmp_valid_in;
         delim_ff     <= delim_in;
         end_ff       <= end_in;
         window_ff    <= window_in;
         fill_ff      <= fill_in;
         running_ff   <= running_in;
         length_ff    <= length_in;
         count_ff     <= count_in;
         overhead_ff  <= overhead_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      best_ff      <= best_in;
      wr_slot_ff   <= wr_slot_in;
      wr_len_ff    <= wr_len_in;
      wr_bytes_ff  <= wr_bytes_in;
      rsp_count_ff <= rsp_count_in;
   end

   `ASSERT_ALWAYS(a_fill_bound, clock, reset, fill_ff <= MaxMatchW, "window fill beyond match limit")
   `ASSERT_IMPLY(a_idle_fill, clock, reset, state_ff == ST_IDLE, fill_ff < MaxMatchW, "full window left undecided")
   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CountLimit, "valid entry count beyond depth")
   `ASSERT_NEXT(a_tail_apply, clock, reset, state_ff == ST_TAIL, state_ff == ST_APPLY, "scan tail not followed by apply")

endmodule
